/* rtl/led_pattern_sequencer_defines.svh */
// Assertion macros for the LED pattern sequencer.
// The macros assume a clock named clk and an active-low reset named arst_n in scope.
`ifndef LED_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_PATTERN_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define LPS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("%m: check failed");
`define LPS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: check failed");
`else
`define LPS_ASSERT_NOW(lbl, pre, post)
`define LPS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* rtl/lps_pkg.sv */
package lps_pkg;

	localparam int PATTERN_DEPTH = 16;
	localparam int IDX_W         = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int STEP_W        = 8;
	localparam int TIME_W        = 32;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [STEP_W-1:0] DEPTH_STEP = STEP_W'(PATTERN_DEPTH);

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_ON     = 3'd1,
		MODE_BLINK  = 3'd2,
		MODE_COUNT  = 3'd3,
		MODE_CUSTOM = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REQ_UPDATE  = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_WRITE   = 2'd2
	} req_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_MODE            = 3'd0,
		CFG_ACTIVE_HIGH     = 3'd1,
		CFG_ON_TIME         = 3'd2,
		CFG_OFF_TIME        = 3'd3,
		CFG_PAUSE_TIME      = 3'd4,
		CFG_LONG_PAUSE_TIME = 3'd5,
		CFG_PULSE_COUNT     = 3'd6,
		CFG_PATTERN_LENGTH  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic              active_high;
		logic [TIME_W-1:0] on_time;
		logic [TIME_W-1:0] off_time;
		logic [TIME_W-1:0] pause_time;
		logic [TIME_W-1:0] long_pause_time;
		logic [5:0]        pulse_count;
		logic [4:0]        pattern_length;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic              clear;
		logic [STEP_W:0]   num;
		logic [STEP_W-1:0] modulus;
	} wrap_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [STEP_W:0] rem;
	} wrap_sts_t;

	typedef struct packed {
		logic s1_valid;
		logic wrap_busy;
	} core_sts_t;

endpackage

/* rtl/lps_if.sv */
interface lps_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] now_time;
	logic [3:0]  entry_index;
	logic [31:0] entry_value;

	modport source (output valid, req_type, now_time, entry_index, entry_value, input ready);
	modport sink (input valid, req_type, now_time, entry_index, entry_value, output ready);
endinterface

interface lps_res_if;
	logic       valid;
	logic       ready;
	logic       pin_level;
	logic       led_lit;
	logic [7:0] step_now;

	modport source (output valid, pin_level, led_lit, step_now, input ready);
	modport sink (input valid, pin_level, led_lit, step_now, output ready);
endinterface

/* rtl/led_pattern_sequencer.sv */
// Channel  Role    Beat fields
// req      sink    req_type, now_time, entry_index, entry_value
// res      source  pin_level, led_lit, step_now
// cfg_*    write   cfg_wen, cfg_addr, cfg_wdata
//
// One beat per cycle unless the result stalls or a wrap runs:
// input register, one pass of update logic, result register.
// A count or custom step index left past the wrap point holds the input stage
// while the wrap subtractor reduces it.
// Reset clears step, step start time, LED state and config, but sets active_high; the duration table is not reset.
// A stalled result blocks the input only once the input stage is also full.
`include "led_pattern_sequencer_defines.svh"

module led_pattern_sequencer import lps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lps_req_if.sink               req,
	lps_res_if.source             res
);

	cfg_t      cfg;
	core_sts_t sts;

	lps_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	lps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.res    (res),
		.sts    (sts)
	);

	`LPS_ASSERT_NOW(a_full_stall_blocks, res.valid && !res.ready && sts.s1_valid, !req.ready)
	`LPS_ASSERT_NOW(a_wrap_has_item, sts.wrap_busy, sts.s1_valid)
	`LPS_ASSERT_NOW(a_pin_polarity, res.valid, res.pin_level == (res.led_lit ^ !cfg.active_high))
	`LPS_ASSERT_NEXT(a_accept_fills_s1, req.valid && req.ready, sts.s1_valid)

endmodule

/* rtl/lps_cfg_regs.sv */
module lps_cfg_regs import lps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wen,
	input  logic [CFG_ADDR_W-1:0] addr,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_OFF, active_high: 1'b1, default: '0};
		end else if (wen) begin
			unique case (cfg_reg_t'(addr))
				CFG_MODE:            cfg_q.mode            <= wdata[2:0];
				CFG_ACTIVE_HIGH:     cfg_q.active_high     <= wdata[0];
				CFG_ON_TIME:         cfg_q.on_time         <= wdata[TIME_W-1:0];
				CFG_OFF_TIME:        cfg_q.off_time        <= wdata[TIME_W-1:0];
				CFG_PAUSE_TIME:      cfg_q.pause_time      <= wdata[TIME_W-1:0];
				CFG_LONG_PAUSE_TIME: cfg_q.long_pause_time <= wdata[TIME_W-1:0];
				CFG_PULSE_COUNT:     cfg_q.pulse_count     <= wdata[5:0];
				CFG_PATTERN_LENGTH:  cfg_q.pattern_length  <= wdata[4:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/lps_wrap_div.sv */
// Step wrap for an index that lies past the modulus: repeated subtraction, one per cycle.
module lps_wrap_div import lps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  wrap_req_t req,
	output wrap_sts_t sts
);

	logic            busy_q;
	logic [STEP_W:0] rem_q;
	logic [STEP_W:0] mod_ext;

	assign mod_ext = {1'b0, req.modulus};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (req.clear) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			rem_q  <= req.num - mod_ext;
		end else if (busy_q && (rem_q >= mod_ext)) begin
			rem_q <= rem_q - mod_ext;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (rem_q < mod_ext);
	assign sts.rem  = rem_q;

endmodule

/* rtl/lps_core.sv */
module lps_core import lps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	lps_req_if.sink          req,
	lps_res_if.source        res,
	output core_sts_t        sts
);

	// input stage
	logic              valid_s1;
	logic [1:0]        req_type_s1;
	logic [TIME_W-1:0] now_time_s1;
	logic [3:0]        entry_index_s1;
	logic [TIME_W-1:0] entry_value_s1;

	// sequencer state
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] start_q;
	logic              lit_q;
	logic [TIME_W-1:0] table_q [PATTERN_DEPTH];

	// result register
	logic              res_valid_q;
	logic              pin_q;
	logic              lit_out_q;
	logic [STEP_W-1:0] step_out_q;

	mode_t             eff_mode;
	logic [STEP_W-1:0] len_raw;
	logic [STEP_W-1:0] used_len;
	logic [STEP_W-1:0] cnt;
	logic [STEP_W-1:0] two_c;
	logic [STEP_W-1:0] total;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] dur;
	logic              expired;
	logic [STEP_W:0]   step_inc;
	logic [STEP_W-1:0] modulus;
	logic              wrap_sel;
	logic              wrap_need;
	logic [STEP_W-1:0] wrap_step;
	logic [STEP_W-1:0] nxt_step;
	logic [TIME_W-1:0] nxt_start;
	logic              nxt_lit;
	logic              tbl_we;
	logic [STEP_W-1:0] widx_ext;
	logic              item_done;
	logic              advance;
	wrap_req_t         wrap_req;
	wrap_sts_t         wrap_sts;

	assign len_raw  = STEP_W'(cfg.pattern_length);
	assign used_len = (len_raw > DEPTH_STEP) ? DEPTH_STEP : len_raw;
	assign cnt      = STEP_W'(cfg.pulse_count);
	assign two_c    = cnt << 1;
	assign total    = (cnt << 2) + STEP_W'(2);

	always_comb begin
		priority if (cfg.mode == MODE_ON) begin
			eff_mode = MODE_ON;
		end else if (cfg.mode == MODE_BLINK) begin
			eff_mode = MODE_BLINK;
		end else if ((cfg.mode == MODE_COUNT) && (cnt != '0)) begin
			eff_mode = MODE_COUNT;
		end else if ((cfg.mode == MODE_CUSTOM) && (used_len != '0)) begin
			eff_mode = MODE_CUSTOM;
		end else begin
			eff_mode = MODE_OFF;
		end
	end

	assign elapsed  = now_time_s1 - start_q;
	assign expired  = elapsed >= dur;
	assign step_inc = {1'b0, step_q} + (STEP_W+1)'(1);

	always_comb begin
		dur      = '0;
		modulus  = total;
		wrap_sel = 1'b0;
		nxt_lit  = lit_q;
		unique case (eff_mode)
			MODE_OFF: nxt_lit = 1'b0;
			MODE_ON:  nxt_lit = 1'b1;
			MODE_BLINK: begin
				dur = step_q[0] ? cfg.off_time : cfg.on_time;
				if (expired) begin
					nxt_lit = step_q[0];
				end
			end
			MODE_COUNT: begin
				wrap_sel = 1'b1;
				priority if (step_q < two_c) begin
					nxt_lit = ~step_q[0];
					dur     = step_q[0] ? cfg.off_time : cfg.on_time;
				end else if (step_q == two_c) begin
					nxt_lit = 1'b0;
					dur     = cfg.pause_time;
				end else if (step_q < total - STEP_W'(1)) begin
					// second group starts on an odd index
					nxt_lit = step_q[0];
					dur     = step_q[0] ? cfg.on_time : cfg.off_time;
				end else begin
					nxt_lit = 1'b0;
					dur     = cfg.long_pause_time;
				end
			end
			MODE_CUSTOM: begin
				wrap_sel = 1'b1;
				modulus  = used_len;
				nxt_lit  = ~step_q[0];
				dur      = (step_q < used_len) ? table_q[step_q[IDX_W-1:0]] : '0;
			end
		endcase
	end

	always_comb begin
		if (step_inc == {1'b0, modulus}) begin
			wrap_step = '0;
		end else if (step_inc < {1'b0, modulus}) begin
			wrap_step = step_inc[STEP_W-1:0];
		end else begin
			wrap_step = wrap_sts.rem[STEP_W-1:0];
		end
	end

	always_comb begin
		nxt_step  = step_q;
		nxt_start = start_q;
		wrap_need = 1'b0;
		tbl_we    = 1'b0;
		unique case (req_type_s1)
			REQ_UPDATE: begin
				if (expired && ((eff_mode == MODE_BLINK) || wrap_sel)) begin
					nxt_start = now_time_s1;
				end
				if (expired && (eff_mode == MODE_BLINK)) begin
					nxt_step = {{(STEP_W-1){1'b0}}, ~step_q[0]};
				end else if (expired && wrap_sel) begin
					nxt_step  = wrap_step;
					wrap_need = step_inc > {1'b0, modulus};
				end
			end
			REQ_RESTART: begin
				nxt_step  = '0;
				nxt_start = now_time_s1;
			end
			REQ_WRITE: tbl_we = widx_ext < DEPTH_STEP;
			default: ;
		endcase
	end

	logic res_lit;
	always_comb begin
		unique case (req_type_s1)
			REQ_UPDATE:  res_lit = nxt_lit;
			REQ_RESTART: res_lit = eff_mode != MODE_OFF;
			default:     res_lit = lit_q;
		endcase
	end

	assign widx_ext = STEP_W'(entry_index_s1);

	assign item_done = !wrap_need || wrap_sts.done;
	assign advance   = valid_s1 && item_done && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	assign wrap_req.start   = valid_s1 && wrap_need && !wrap_sts.busy;
	assign wrap_req.clear   = advance;
	assign wrap_req.num     = step_inc;
	assign wrap_req.modulus = modulus;

	lps_wrap_div u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wrap_req),
		.sts    (wrap_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1    <= req.req_type;
			now_time_s1    <= req.now_time;
			entry_index_s1 <= req.entry_index;
			entry_value_s1 <= req.entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			start_q <= '0;
			lit_q   <= 1'b0;
		end else if (advance) begin
			step_q  <= nxt_step;
			start_q <= nxt_start;
			lit_q   <= res_lit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tbl_we) begin
			table_q[widx_ext[IDX_W-1:0]] <= entry_value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pin_q      <= cfg.active_high ? res_lit : ~res_lit;
			lit_out_q  <= res_lit;
			step_out_q <= nxt_step;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.pin_level = pin_q;
	assign res.led_lit   = lit_out_q;
	assign res.step_now  = step_out_q;

	assign sts.s1_valid  = valid_s1;
	assign sts.wrap_busy = wrap_sts.busy;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import lps_pkg::*;

	localparam logic [1:0] REQ_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now;
		logic [3:0]  idx;
		logic [31:0] val;
	} led_req_t;

	typedef struct packed {
		logic       pin;
		logic       lit;
		logic [7:0] step;
	} led_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	lps_req_if req_ch();
	lps_res_if res_ch();

	led_pattern_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	led_req_t    pending_reqs[$];
	led_out_t    expected_leds[$];
	led_req_t    next_beat;
	int          mismatches;
	bit          steady;
	logic [31:0] wall_ms;

	// predictor state
	cfg_t        cfg;
	logic [7:0]  cur_step;
	logic [31:0] step_t0;
	logic        lit_now;
	logic [31:0] dur_tbl [PATTERN_DEPTH];

	function automatic int used_len();
		return (cfg.pattern_length > PATTERN_DEPTH) ? PATTERN_DEPTH : int'(cfg.pattern_length);
	endfunction

	function automatic mode_t live_mode();
		if (cfg.mode > MODE_CUSTOM) return MODE_OFF;
		if (cfg.mode == MODE_COUNT && cfg.pulse_count == 0) return MODE_OFF;
		if (cfg.mode == MODE_CUSTOM && used_len() == 0) return MODE_OFF;
		return mode_t'(cfg.mode);
	endfunction

	function automatic led_out_t apply_led_req(led_req_t b);
		int          s;
		int          c;
		int          len;
		logic [31:0] dur;
		logic [31:0] elapsed;
		led_out_t    r;
		s = cur_step;
		elapsed = b.now - step_t0;
		case (b.kind)
			REQ_UPDATE: begin
				case (live_mode())
					MODE_OFF: lit_now = 1'b0;
					MODE_ON: lit_now = 1'b1;
					MODE_BLINK: begin
						dur = (s % 2) ? cfg.off_time : cfg.on_time;
						if (elapsed >= dur) begin
							step_t0 = b.now;
							cur_step = 8'((s + 1) % 2);
							lit_now = !cur_step[0];
						end
					end
					MODE_COUNT: begin
						c = cfg.pulse_count;
						if (s < 2 * c) begin
							lit_now = (s % 2 == 0);
							dur = (s % 2) ? cfg.off_time : cfg.on_time;
						end else if (s == 2 * c) begin
							lit_now = 1'b0;
							dur = cfg.pause_time;
						end else if (s < 4 * c + 1) begin
							lit_now = ((s - 2 * c - 1) % 2 == 0);
							dur = ((s - 2 * c - 1) % 2) ? cfg.off_time : cfg.on_time;
						end else begin
							// long pause, also any step left over from another mode
							lit_now = 1'b0;
							dur = cfg.long_pause_time;
						end
						if (elapsed >= dur) begin
							step_t0 = b.now;
							cur_step = 8'((s + 1) % (4 * c + 2));
						end
					end
					MODE_CUSTOM: begin
						len = used_len();
						dur = (s < len) ? dur_tbl[s] : '0;
						lit_now = (s % 2 == 0);
						if (elapsed >= dur) begin
							step_t0 = b.now;
							cur_step = 8'((s + 1) % len);
						end
					end
					default: lit_now = 1'b0;
				endcase
			end
			REQ_RESTART: begin
				cur_step = '0;
				step_t0 = b.now;
				lit_now = (live_mode() != MODE_OFF);
			end
			REQ_WRITE: dur_tbl[b.idx] = b.val;
			default: ;
		endcase
		r.pin = cfg.active_high ? lit_now : !lit_now;
		r.lit = lit_now;
		r.step = cur_step;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= '0;
			req_ch.now_time <= '0;
			req_ch.entry_index <= '0;
			req_ch.entry_value <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
				next_beat = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.req_type <= next_beat.kind;
				req_ch.now_time <= next_beat.now;
				req_ch.entry_index <= next_beat.idx;
				req_ch.entry_value <= next_beat.val;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= steady || ($urandom_range(99) >= 12);
	end

	// monitor: check result beats, predict on request beats
	always @(posedge clk) begin : watch_leds
		led_out_t want;
		led_req_t got;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_leds.size() == 0) begin
					$error("result beat with no request outstanding");
					mismatches++;
				end else begin
					want = expected_leds.pop_front();
					if (res_ch.pin_level !== want.pin) begin
						$error("pin_level: expected %0d, got %0d", want.pin, res_ch.pin_level);
						mismatches++;
					end
					if (res_ch.led_lit !== want.lit) begin
						$error("led_lit: expected %0d, got %0d", want.lit, res_ch.led_lit);
						mismatches++;
					end
					if (res_ch.step_now !== want.step) begin
						$error("step_now: expected %0d, got %0d", want.step, res_ch.step_now);
						mismatches++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				got = '{req_ch.req_type, req_ch.now_time, req_ch.entry_index,
					req_ch.entry_value};
				expected_leds.push_back(apply_led_req(got));
			end
		end
	end

	task automatic send(logic [1:0] kind, logic [31:0] now, logic [3:0] idx, logic [31:0] val);
		pending_reqs.push_back('{kind, now, idx, val});
	endtask

	task automatic tick(int max_adv);
		wall_ms += $urandom_range(max_adv);
		send(REQ_UPDATE, wall_ms, 4'($urandom), $urandom);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_leds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t a, logic [31:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		case (a)
			CFG_MODE: cfg.mode = v[2:0];
			CFG_ACTIVE_HIGH: cfg.active_high = v[0];
			CFG_ON_TIME: cfg.on_time = v;
			CFG_OFF_TIME: cfg.off_time = v;
			CFG_PAUSE_TIME: cfg.pause_time = v;
			CFG_LONG_PAUSE_TIME: cfg.long_pause_time = v;
			CFG_PULSE_COUNT: cfg.pulse_count = v[5:0];
			CFG_PATTERN_LENGTH: cfg.pattern_length = v[4:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// narrow registers get junk in the unused upper bits
	task automatic setup(logic [2:0] m, logic ah, logic [31:0] t_on, logic [31:0] t_off,
		logic [31:0] t_pause, logic [31:0] t_long, logic [5:0] pc, logic [4:0] pl);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(CFG_MODE, {junk[31:3], m});
		write_reg(CFG_ACTIVE_HIGH, {junk[30:0], ah});
		write_reg(CFG_ON_TIME, t_on);
		write_reg(CFG_OFF_TIME, t_off);
		write_reg(CFG_PAUSE_TIME, t_pause);
		write_reg(CFG_LONG_PAUSE_TIME, t_long);
		write_reg(CFG_PULSE_COUNT, {junk[25:0], pc});
		write_reg(CFG_PATTERN_LENGTH, {junk[26:0], pl});
	endtask

	task automatic run_phase(int n, int max_adv, bit restart);
		int r;
		if (restart)
			send(REQ_RESTART, wall_ms, 4'($urandom), $urandom);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 78) begin
				tick(max_adv);
			end else if (r < 84) begin
				wall_ms += $urandom_range(max_adv);
				send(REQ_RESTART, wall_ms, 4'($urandom), $urandom);
			end else if (r < 90) begin
				send(REQ_WRITE, $urandom, 4'($urandom),
					($urandom_range(7) == 0) ? $urandom : $urandom_range(12));
			end else if (r < 94) begin
				send(REQ_IGNORED, $urandom, 4'($urandom), $urandom);
			end else begin
				wall_ms = $urandom;
				send(REQ_UPDATE, wall_ms, 4'($urandom), $urandom);
			end
		end
		drain();
	endtask

	function automatic logic [31:0] pick_ms();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			default: return $urandom_range(8, 1);
		endcase
	endfunction

	initial begin
		int          k;
		int          r;
		logic [2:0]  m;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = CFG_MODE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.now_time = '0;
		req_ch.entry_index = '0;
		req_ch.entry_value = '0;
		res_ch.ready = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		wall_ms = '0;
		cfg = '0;
		cfg.active_high = 1'b1;
		cur_step = '0;
		step_t0 = '0;
		lit_now = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole table first so no unwritten entry is ever read
		for (k = 0; k < PATTERN_DEPTH; k++)
			send(REQ_WRITE, $urandom, 4'(k), (k == PATTERN_DEPTH - 1) ? '1 : 32'(k % 4));
		send(REQ_UPDATE, '0, '0, '0);
		send(REQ_IGNORED, '1, '1, '1);
		send(REQ_RESTART, '1, '0, '0);
		drain();

		setup(MODE_ON, 1'b0, '1, '0, '1, '0, 6'd0, 5'd0);
		run_phase(12, 4, 1);

		wall_ms = 32'hFFFF_FFF0;
		setup(MODE_BLINK, 1'b1, 32'd3, 32'd5, '0, '0, 6'd1, 5'd1);
		run_phase(40, 6, 1);

		steady = 1'b1;
		setup(MODE_COUNT, 1'b1, 32'd2, 32'd3, 32'd6, 32'd10, 6'd2, 5'd4);
		run_phase(80, 5, 1);
		steady = 1'b0;

		setup(MODE_COUNT, 1'b0, 32'd2, 32'd3, 32'd6, 32'd10, 6'd0, 5'd4);
		run_phase(12, 5, 1);

		setup(MODE_CUSTOM, 1'b1, '0, '0, '0, '0, 6'd3, 5'd5);
		run_phase(60, 4, 1);

		setup(MODE_CUSTOM, 1'b1, '0, '0, '0, '0, 6'd3, 5'd0);
		run_phase(10, 4, 1);

		setup(MODE_CUSTOM, 1'b0, '0, '0, '0, '0, 6'd3, 5'd31);
		run_phase(40, 4, 1);

		setup(3'($urandom_range(7, 5)), 1'b1, 32'd1, 32'd1, 32'd1, 32'd1, 6'd1, 5'd1);
		run_phase(10, 4, 1);

		// walk the count pattern to a high step, then hand it to a mode that wraps shorter
		for (k = 0; k < 2; k++) begin
			setup(MODE_COUNT, 1'b1, '0, '0, '0, '0, 6'd63, 5'd3);
			send(REQ_RESTART, wall_ms, '0, '0);
			repeat ($urandom_range(70, 40))
				send(REQ_UPDATE, wall_ms, 4'($urandom), $urandom);
			drain();
			if (k == 0) begin
				write_reg(CFG_MODE, 32'(MODE_CUSTOM));
			end else begin
				write_reg(CFG_ON_TIME, '1);
				write_reg(CFG_OFF_TIME, '1);
				write_reg(CFG_MODE, 32'(MODE_BLINK));
				tick(2);
				tick(2);
				drain();
				write_reg(CFG_ON_TIME, '0);
				write_reg(CFG_OFF_TIME, '0);
				write_reg(CFG_PULSE_COUNT, 32'd1);
				write_reg(CFG_MODE, 32'(MODE_COUNT));
			end
			repeat (3) tick(2);
			drain();
		end

		repeat (10) begin
			r = $urandom_range(9);
			m = (r < 1) ? MODE_OFF : (r < 2) ? MODE_ON : (r < 4) ? MODE_BLINK :
				(r < 7) ? MODE_COUNT : (r < 9) ? MODE_CUSTOM : 3'($urandom_range(7, 5));
			if ($urandom_range(4) == 0)
				wall_ms = 32'hFFFF_FFFF - $urandom_range(20);
			setup(m, 1'($urandom_range(1)), pick_ms(), pick_ms(), pick_ms(), pick_ms(),
				($urandom_range(5) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(4, 1)),
				($urandom_range(5) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1)));
			run_phase($urandom_range(22, 14), 6, 1'($urandom_range(1)));
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_leds.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
